FILE: rtl/core/multi_key_debounce_hold_events_assert.svh
// Assertion macros shared by the debouncer checker
`ifndef MULTI_KEY_DEBOUNCE_HOLD_EVENTS_ASSERT_SVH
`define MULTI_KEY_DEBOUNCE_HOLD_EVENTS_ASSERT_SVH

// clocked check, off while reset is asserted
`define MKD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define MKD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mkdhe_pkg.sv
// Shared types and constants of the multi-key debouncer
`default_nettype none

package mkdhe_pkg;

    localparam int CFG_W = 16;
    localparam int KEYS_W = 4;
    localparam int LEVELS_W = 8;
    localparam int INDEX_W = 3;

    localparam logic [CFG_W-1:0]  HOLD_RESET = 16'd5;
    localparam logic [CFG_W-1:0]  LONG_RESET = 16'd100;
    localparam logic [KEYS_W-1:0] KEYS_RESET = 4'd8;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_HOLD    = 2'd1,
        EV_RELEASE = 2'd2
    } ev_t;

    typedef enum logic [1:0] {
        REG_HOLD = 2'd0,
        REG_LONG = 2'd1,
        REG_KEYS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic fire;
        ev_t  code;
    } key_evt_t;

endpackage

`default_nettype wire

FILE: rtl/core/mkdhe_key.sv
// One key lane: debounce counters, debounced level and event decision
`default_nettype none

module mkdhe_key #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic                       pressed,
    input  wire logic [mkdhe_pkg::CFG_W-1:0] hold_count,
    input  wire logic [mkdhe_pkg::CFG_W-1:0] long_hold_count,
    output mkdhe_pkg::key_evt_t             evt
);

    localparam int CMP_W = (COUNT_WIDTH > mkdhe_pkg::CFG_W) ? COUNT_WIDTH : mkdhe_pkg::CFG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                   on_reg, on_next;
    logic [COUNT_WIDTH-1:0] press_reg, press_next;
    logic [COUNT_WIDTH-1:0] release_reg, release_next;
    logic [COUNT_WIDTH-1:0] press_inc, release_inc;
    logic [CMP_W-1:0]       press_cmp, release_cmp, hold_cmp, long_cmp;

    always_comb
    begin
        press_inc   = (press_reg == CNT_MAX) ? CNT_MAX : press_reg + 1'b1;
        release_inc = (release_reg == CNT_MAX) ? CNT_MAX : release_reg + 1'b1;
        press_cmp   = CMP_W'(press_inc);
        release_cmp = CMP_W'(release_inc);
        hold_cmp    = CMP_W'(hold_count);
        long_cmp    = CMP_W'(long_hold_count);
    end

    always_comb
    begin
        on_next      = on_reg;
        press_next   = press_reg;
        release_next = release_reg;
        evt.fire     = 1'b0;
        evt.code     = mkdhe_pkg::EV_PRESS;
        if (step)
        begin
            if (on_reg)
            begin
                if (pressed)
                begin
                    press_next   = press_inc;
                    release_next = '0;
                    if ((press_reg != CNT_MAX) && (press_cmp == long_cmp))
                    begin
                        evt.fire = 1'b1;
                        evt.code = mkdhe_pkg::EV_HOLD;
                    end
                end
                else
                begin
                    release_next = release_inc;
                    if (release_cmp >= hold_cmp)
                    begin
                        on_next      = 1'b0;
                        press_next   = '0;
                        release_next = '0;
                        evt.fire     = 1'b1;
                        evt.code     = mkdhe_pkg::EV_RELEASE;
                    end
                end
            end
            else
            begin
                if (pressed)
                begin
                    press_next = press_inc;
                    if (press_cmp >= hold_cmp)
                    begin
                        on_next  = 1'b1;
                        evt.fire = 1'b1;
                        evt.code = mkdhe_pkg::EV_PRESS;
                    end
                end
                else
                begin
                    press_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg      <= 1'b0;
            press_reg   <= '0;
            release_reg <= '0;
        end
        else
        begin
            on_reg      <= on_next;
            press_reg   <= press_next;
            release_reg <= release_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/multi_key_debounce_hold_events.sv
// Top level of the multi-key debouncer with press, long-hold and release events
//
//   channel   direction  handshake                 payload
//   key       in         key_valid / key_stall     key_levels
//   event     out        event_valid / event_stall key_index, event_code, last_event
//   config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// A tick beat is registered, then all enabled key lanes update together and their
// events land in a pending buffer. The buffer drains one event beat per cycle
// in key order while event_stall is low. A new tick is taken while the previous
// tick's last event still sits in the output register. Reset clears all counters
// and debounced levels at once. Stalls on the event side back up into key_stall.
`default_nettype none

module multi_key_debounce_hold_events #(
    parameter int NUM_KEYS    = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  key_valid,
    output      logic                                  key_stall,
    input  wire logic [mkdhe_pkg::LEVELS_W-1:0]        key_levels,
    output      logic                                  event_valid,
    input  wire logic                                  event_stall,
    output      logic [mkdhe_pkg::INDEX_W-1:0]         key_index,
    output      logic [1:0]                            event_code,
    output      logic                                  last_event,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [3:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output      logic [31:0]                           prdata,
    output      logic                                  pready
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [mkdhe_pkg::CFG_W-1:0]    hold_count_reg;
    logic [mkdhe_pkg::CFG_W-1:0]    long_hold_count_reg;
    logic [mkdhe_pkg::KEYS_W-1:0]   key_count_reg;
    logic                           cfg_write;

    logic                           in_valid_reg, in_valid_next;
    logic [mkdhe_pkg::LEVELS_W-1:0] levels_reg;
    logic                           key_accept;
    logic                           process;

    logic [NUM_KEYS-1:0]            key_en;
    logic [NUM_KEYS-1:0]            key_pressed;
    mkdhe_pkg::key_evt_t            evts [NUM_KEYS];
    logic [NUM_KEYS-1:0]            new_mask;

    logic [NUM_KEYS-1:0]            mask_reg, mask_next;
    mkdhe_pkg::ev_t                 code_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0]            low_bit, rest_mask, mask_left;
    logic [KW-1:0]                  pick_idx;
    logic                           pick;
    logic                           load_out;

    logic                           event_valid_reg, event_valid_next;
    logic [mkdhe_pkg::INDEX_W-1:0]  key_index_reg;
    mkdhe_pkg::ev_t                 event_code_reg;
    logic                           last_event_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (mkdhe_pkg::reg_idx_t'(paddr[3:2]))
            mkdhe_pkg::REG_HOLD: prdata = 32'(hold_count_reg);
            mkdhe_pkg::REG_LONG: prdata = 32'(long_hold_count_reg);
            mkdhe_pkg::REG_KEYS: prdata = 32'(key_count_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg      <= mkdhe_pkg::HOLD_RESET;
            long_hold_count_reg <= mkdhe_pkg::LONG_RESET;
            key_count_reg       <= mkdhe_pkg::KEYS_RESET;
        end
        else if (cfg_write)
        begin
            case (mkdhe_pkg::reg_idx_t'(paddr[3:2]))
                mkdhe_pkg::REG_HOLD: hold_count_reg      <= pwdata[mkdhe_pkg::CFG_W-1:0];
                mkdhe_pkg::REG_LONG: long_hold_count_reg <= pwdata[mkdhe_pkg::CFG_W-1:0];
                mkdhe_pkg::REG_KEYS: key_count_reg       <= pwdata[mkdhe_pkg::KEYS_W-1:0];
                default:             ;
            endcase
        end
    end

    // input register
    assign key_accept = key_valid && !key_stall;
    assign key_stall  = in_valid_reg && !process;

    always_comb
    begin
        if (key_accept)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_accept)
            levels_reg <= key_levels;
    end

    // key lanes
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_en[k]   = (32'(key_count_reg) > k);
            new_mask[k] = evts[k].fire;
        end
    end

    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_key
        if (g < mkdhe_pkg::LEVELS_W)
        begin : g_pin
            assign key_pressed[g] = !levels_reg[g];
        end
        else
        begin : g_nopin
            assign key_pressed[g] = 1'b0;
        end

        mkdhe_key #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_key (
            .clk             (clk),
            .rst_n           (rst_n),
            .step            (process && key_en[g]),
            .pressed         (key_pressed[g]),
            .hold_count      (hold_count_reg),
            .long_hold_count (long_hold_count_reg),
            .evt             (evts[g])
        );
    end

    // pending events, drained lowest key first
    always_comb
    begin
        low_bit   = mask_reg & (~mask_reg + 1'b1);
        rest_mask = mask_reg & ~low_bit;
        pick_idx  = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
                pick_idx = KW'(k);
        end
        load_out  = !event_valid_reg || !event_stall;
        pick      = (|mask_reg) && load_out;
        mask_left = pick ? rest_mask : mask_reg;
        process   = in_valid_reg && (mask_left == '0);
        mask_next = process ? new_mask : mask_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                code_reg[k] <= evts[k].code;
        end
    end

    // output register
    always_comb
    begin
        if (pick)
            event_valid_next = 1'b1;
        else if (load_out)
            event_valid_next = 1'b0;
        else
            event_valid_next = event_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            event_valid_reg <= 1'b0;
        else
            event_valid_reg <= event_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pick)
        begin
            key_index_reg  <= mkdhe_pkg::INDEX_W'(pick_idx);
            event_code_reg <= code_reg[pick_idx];
            last_event_reg <= (rest_mask == '0);
        end
    end

    assign event_valid = event_valid_reg;
    assign key_index   = key_index_reg;
    assign event_code  = 2'(event_code_reg);
    assign last_event  = last_event_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mkdhe_checker.sv
// Port-level checks of the debouncer and their binding to the top level
`default_nettype none

`include "multi_key_debounce_hold_events_assert.svh"

module mkdhe_checker #(
    parameter int NUM_KEYS = 8
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       event_valid,
    input wire logic       event_stall,
    input wire logic [2:0] key_index,
    input wire logic [1:0] event_code,
    input wire logic       last_event
);

    logic event_beat;

    assign event_beat = event_valid && !event_stall;

    `MKD_ASSERT(a_event_hold,
        event_valid && event_stall |=> event_valid && $stable(key_index)
            && $stable(event_code) && $stable(last_event),
        "stalled event beat changed")

    `MKD_ASSERT(a_tick_continues,
        event_beat && !last_event |=> event_valid,
        "events of one tick not back to back")

    `MKD_ASSERT(a_key_order,
        event_beat && !last_event |=> (NUM_KEYS > 8) || (key_index > $past(key_index)),
        "events of one tick out of key order")

    `MKD_ASSERT_RST(a_reset_quiet, !rst_n |=> !event_valid, "event beat offered during reset")

endmodule

bind multi_key_debounce_hold_events mkdhe_checker #(
    .NUM_KEYS (NUM_KEYS)
) u_mkdhe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .key_index   (key_index),
    .event_code  (event_code),
    .last_event  (last_event)
);

`default_nettype wire
